### rtl/pea_pkg.sv
`timescale 1ns / 1ps

package pea_pkg;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned OFFSET_W = 13;
    localparam int unsigned COUNT_W  = 14;
    localparam int unsigned STATUS_W = 3;

    localparam int unsigned DEF_ARENA_PAGES = 8192;
    localparam int unsigned DEF_FREE_SLOTS  = 64;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC      = 2'd0,
        MODE_FREE       = 2'd1,
        MODE_FIXED      = 2'd2,
        MODE_FIXED_NORP = 2'd3
    } t_mode;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOMEM   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

endpackage

### rtl/pea_if.sv
`timescale 1ns / 1ps

interface pea_req_if
    import pea_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [OFFSET_W-1:0] page_offset;
    logic [COUNT_W-1:0]  page_count;

    modport source (output valid, mode, page_offset, page_count, input ready);
    modport sink   (input valid, mode, page_offset, page_count, output ready);
endinterface

interface pea_rsp_if
    import pea_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] result_offset;

    modport source (output valid, status, result_offset, input ready);
    modport sink   (input valid, status, result_offset, output ready);
endinterface

### rtl/page_extent_allocator.sv
`timescale 1ns / 1ps
// a fixed claim or an invalid request is answered straight from the start state;
// allocate and free scan the free extents one at a time through a read and a check
// state, and read and write each entry that moves when an extent is dropped or
// inserted. One transaction is in flight; no new request is taken until the
// response has been accepted and the block is back in idle.
// reset: extent count and bump mark cleared; extent ram contents are not reset.
module page_extent_allocator
    import pea_pkg::*;
#(
    parameter int unsigned ARENA_PAGES = DEF_ARENA_PAGES,
    parameter int unsigned FREE_SLOTS  = DEF_FREE_SLOTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pea_req_if.sink   i_req,
    pea_rsp_if.source o_rsp
);

    localparam int unsigned AW = $clog2(ARENA_PAGES + 1);
    localparam int unsigned CW = (AW > COUNT_W) ? AW : COUNT_W;
    localparam int unsigned IW = $clog2(FREE_SLOTS);
    localparam logic [CW:0] ARENA = (CW+1)'(ARENA_PAGES);
    localparam logic [IW:0] SLOTS = (IW+1)'(FREE_SLOTS);

    typedef struct packed {
        logic [CW-1:0] start;
        logic [CW-1:0] len;
    } t_ext;

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RD, S_CHK, S_BUMP, S_FDEC,
        S_DN_RD, S_DN_WR, S_UP_RD, S_UP_WR, S_INS, S_OUT
    } t_state;

    t_state              r_state;
    t_mode               r_mode;
    logic [CW-1:0]       r_first;
    logic [CW-1:0]       r_pages;
    logic [IW:0]         r_cnt;
    logic [CW-1:0]       r_bump;
    logic [IW:0]         r_idx;
    logic [IW:0]         r_j;
    t_ext                r_prev;
    t_ext                r_nxt;
    logic                r_has_nxt;
    logic [STATUS_W-1:0] r_status;
    logic [OFFSET_W-1:0] r_where;

    t_ext         mem [FREE_SLOTS];
    t_ext         r_rd;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wa;
    t_ext          wd;

    logic [CW:0] end_pos;
    logic        in_arena;
    logic        join_next;
    logic        join_prev;

    assign end_pos   = (CW+1)'(r_first) + (CW+1)'(r_pages);
    assign in_arena  = end_pos <= ARENA;
    assign join_next = r_has_nxt && (end_pos == (CW+1)'(r_nxt.start));
    assign join_prev = (r_idx != '0) &&
                       ((CW+1)'(r_prev.start) + (CW+1)'(r_prev.len) == (CW+1)'(r_first));

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = (r_state == S_OUT);
    assign o_rsp.status        = r_status;
    assign o_rsp.result_offset = r_where;

    always_comb begin
        rd_addr = r_idx[IW-1:0];
        if (r_state == S_DN_RD || r_state == S_UP_RD) begin
            rd_addr = r_j[IW-1:0];
        end
    end

    // ram write port
    always_comb begin
        we = 1'b0;
        wa = r_idx[IW-1:0];
        wd = r_rd;
        unique case (r_state)
            S_CHK: begin
                if (r_mode == MODE_ALLOC && r_rd.len > r_pages) begin
                    we = 1'b1;
                    wd = '{start: r_rd.start + r_pages, len: r_rd.len - r_pages};
                end
            end
            S_FDEC: begin
                if (join_prev) begin
                    we = 1'b1;
                    wa = IW'(r_idx - 1'b1);
                    wd = '{start: r_prev.start,
                           len: r_prev.len + r_pages + (join_next ? r_nxt.len : '0)};
                end else if (join_next) begin
                    we = 1'b1;
                    wd = '{start: r_first, len: r_nxt.len + r_pages};
                end
            end
            S_DN_WR: begin
                we = 1'b1;
                wa = IW'(r_j - 1'b1);
            end
            S_UP_WR: begin
                we = 1'b1;
                wa = IW'(r_j + 1'b1);
            end
            S_INS: begin
                we = 1'b1;
                wd = '{start: r_first, len: r_pages};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_bump   <= '0;
            r_status <= ST_OK;
            r_where  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_mode    <= t_mode'(i_req.mode);
                        r_first   <= CW'(i_req.page_offset);
                        r_pages   <= CW'(i_req.page_count);
                        r_where   <= '0;
                        r_idx     <= '0;
                        r_has_nxt <= 1'b0;
                        r_state   <= S_START;
                    end
                end
                S_START: begin
                    if (r_pages == '0) begin
                        r_status <= ST_INVALID;
                        r_state  <= S_OUT;
                    end else begin
                        unique case (r_mode)
                            MODE_ALLOC: r_state <= (r_cnt == '0) ? S_BUMP : S_RD;
                            MODE_FREE: begin
                                if (!in_arena) begin
                                    r_status <= ST_INVALID;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_state <= (r_cnt == '0) ? S_FDEC : S_RD;
                                end
                            end
                            MODE_FIXED, MODE_FIXED_NORP: begin
                                r_state <= S_OUT;
                                if (!in_arena) begin
                                    r_status <= ST_NOMEM;
                                end else if (r_mode == MODE_FIXED_NORP && r_first < r_bump) begin
                                    r_status <= ST_EXISTS;
                                end else begin
                                    r_status <= ST_OK;
                                    r_where  <= OFFSET_W'(r_first);
                                    if (end_pos > (CW+1)'(r_bump)) begin
                                        r_bump <= CW'(end_pos);
                                    end
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_mode == MODE_ALLOC) begin
                        if (r_rd.len >= r_pages) begin
                            r_where  <= OFFSET_W'(r_rd.start);
                            r_status <= ST_OK;
                            if (r_rd.len > r_pages) begin
                                r_state <= S_OUT;
                            end else if (r_idx + 1'b1 < r_cnt) begin
                                r_j     <= r_idx + 1'b1;
                                r_state <= S_DN_RD;
                            end else begin
                                r_cnt   <= r_cnt - 1'b1;
                                r_state <= S_OUT;
                            end
                        end else if (r_idx + 1'b1 < r_cnt) begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_BUMP;
                        end
                    end else begin
                        if (r_rd.start < r_first) begin
                            r_prev  <= r_rd;
                            r_idx   <= r_idx + 1'b1;
                            r_state <= (r_idx + 1'b1 < r_cnt) ? S_RD : S_FDEC;
                        end else begin
                            r_nxt     <= r_rd;
                            r_has_nxt <= 1'b1;
                            r_state   <= S_FDEC;
                        end
                    end
                end
                S_BUMP: begin
                    r_state <= S_OUT;
                    if ((CW+1)'(r_pages) > ARENA - (CW+1)'(r_bump)) begin
                        r_status <= ST_NOMEM;
                    end else begin
                        r_status <= ST_OK;
                        r_where  <= OFFSET_W'(r_bump);
                        r_bump   <= r_bump + r_pages;
                    end
                end
                S_FDEC: begin
                    r_status <= ST_OK;
                    if (join_prev && join_next) begin
                        // merged into the previous extent, next one leaves the table
                        if (r_idx + 1'b1 < r_cnt) begin
                            r_j     <= r_idx + 1'b1;
                            r_state <= S_DN_RD;
                        end else begin
                            r_cnt   <= r_cnt - 1'b1;
                            r_state <= S_OUT;
                        end
                    end else if (join_prev || join_next) begin
                        r_state <= S_OUT;
                    end else if (r_cnt >= SLOTS) begin
                        r_status <= ST_FULL;
                        r_state  <= S_OUT;
                    end else if (r_idx < r_cnt) begin
                        r_j     <= r_cnt - 1'b1;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_INS;
                    end
                end
                S_DN_RD: r_state <= S_DN_WR;
                S_DN_WR: begin
                    if (r_j + 1'b1 < r_cnt) begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_DN_RD;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_UP_RD: r_state <= S_UP_WR;
                S_UP_WR: begin
                    if (r_j == r_idx) begin
                        r_state <= S_INS;
                    end else begin
                        r_j     <= r_j - 1'b1;
                        r_state <= S_UP_RD;
                    end
                end
                S_INS: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
